/* src/kch_pkg.sv */
// Package with the shared constants, payload types and control types of the k-mer counter.
package kch_pkg;

  // K-mer length and the widths that follow from it.
  localparam int unsigned KMER_LEN  = 11;
  localparam int unsigned PAT_BITS  = 2 * KMER_LEN;
  localparam int unsigned CNT_W     = 16;
  localparam int unsigned BASES_W   = 4;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned CODE_W    = 2;

  // Count limit after reset.
  localparam logic [CNT_W-1:0] LIMIT_RESET = 16'd16384;

  // Item kinds.
  localparam logic KIND_BASE = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // ASCII characters that have their own codes.
  localparam logic [CHAR_W-1:0] CHAR_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_C = 8'h63;
  localparam logic [CHAR_W-1:0] CHAR_G = 8'h67;

  // Two-bit nucleotide codes.
  localparam logic [CODE_W-1:0] CODE_T = 2'd0;
  localparam logic [CODE_W-1:0] CODE_C = 2'd1;
  localparam logic [CODE_W-1:0] CODE_A = 2'd2;
  localparam logic [CODE_W-1:0] CODE_G = 2'd3;

  // Input item.
  typedef struct packed {
    logic                kind;
    logic [CHAR_W-1:0]   base_char;
    logic                seq_start;
    logic [PAT_BITS-1:0] read_pattern;
  } kch_in_t;

  // Result item.
  typedef struct packed {
    logic [PAT_BITS-1:0] pattern_code;
    logic [CNT_W-1:0]    pattern_count;
    logic                window_full;
    logic                at_limit;
  } kch_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic lookup;
    logic update;
    logic clear;
  } kch_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;
  } kch_status_t;

  // Map an ASCII character to its code; anything unknown counts as t.
  function automatic logic [CODE_W-1:0] nucleotide_code(input logic [CHAR_W-1:0] ch);
    logic [CODE_W-1:0] code;
    case (ch)
      CHAR_C:  code = CODE_C;
      CHAR_A:  code = CODE_A;
      CHAR_G:  code = CODE_G;
      default: code = CODE_T;
    endcase
    return code;
  endfunction

endpackage

/* src/kch_ctrl.sv */
// Controller state machine of the k-mer counter: table clearing and item sequencing.
module kch_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  kch_pkg::kch_status_t status_i,
  output kch_pkg::kch_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR  = 4'b0001,
    ST_IDLE   = 4'b0010,
    ST_LOOKUP = 4'b0100,
    ST_UPDATE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd_o.lookup = 1'b1;
        state_d      = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // State register; reset starts the clearing pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

/* src/kch_datapath.sv */
// Datapath of the k-mer counter: rolling window, count table, limit register and result.
module kch_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  kch_pkg::kch_cmd_t                   cmd_i,
  output kch_pkg::kch_status_t                status_o,
  input  kch_pkg::kch_in_t                    item_i,
  input  logic                                cfg_valid_i,
  input  logic [kch_pkg::CNT_W-1:0]           cfg_data_i,
  output kch_pkg::kch_out_t                   result_o,
  output logic                                result_valid_o
);

  localparam int unsigned DEPTH = 1 << kch_pkg::PAT_BITS;
  localparam logic [kch_pkg::BASES_W-1:0] BASES_LAST =
    kch_pkg::BASES_W'(kch_pkg::KMER_LEN - 1);

  // Count table.
  logic [kch_pkg::CNT_W-1:0] table_mem [DEPTH];

  logic [kch_pkg::PAT_BITS-1:0] window_q, window_d;
  logic [kch_pkg::BASES_W-1:0]  bases_q, bases_d;
  logic [kch_pkg::PAT_BITS-1:0] pat_q;
  logic                         formed_q;
  logic                         is_read_q;
  logic [kch_pkg::CNT_W-1:0]    rd_q;
  logic [kch_pkg::CNT_W-1:0]    limit_q;
  logic [kch_pkg::PAT_BITS-1:0] clr_addr_q;
  kch_pkg::kch_out_t            result_q, result_d;
  logic                         result_valid_q;

  logic [kch_pkg::PAT_BITS-1:0] win_base;
  logic [kch_pkg::BASES_W-1:0]  bases_base;
  logic                         formed_d;
  logic                         lim;
  logic                         do_write;
  logic [kch_pkg::CNT_W-1:0]    cnt_inc;
  logic                         mem_we;
  logic [kch_pkg::PAT_BITS-1:0] mem_waddr;
  logic [kch_pkg::CNT_W-1:0]    mem_wdata;

  // Window step for a base; a new sequence starts from an empty window.
  always_comb begin
    win_base   = item_i.seq_start ? '0 : window_q;
    bases_base = item_i.seq_start ? '0 : bases_q;
    formed_d   = (bases_base >= BASES_LAST);
    window_d   = {win_base[kch_pkg::PAT_BITS-kch_pkg::CODE_W-1:0],
                  kch_pkg::nucleotide_code(item_i.base_char)};
    bases_d    = formed_d ? bases_base : bases_base + kch_pkg::BASES_W'(1);
  end

  // Window state and the latched item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
      bases_q  <= '0;
    end else if (cmd_i.load && (item_i.kind == kch_pkg::KIND_BASE)) begin
      window_q <= window_d;
      bases_q  <= bases_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      if (item_i.kind == kch_pkg::KIND_READ) begin
        pat_q     <= item_i.read_pattern;
        formed_q  <= 1'b1;
        is_read_q <= 1'b1;
      end else begin
        pat_q     <= window_d;
        formed_q  <= formed_d;
        is_read_q <= 1'b0;
      end
    end
  end

  // Count limit register; the write channel is always ready.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= kch_pkg::LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Clearing pass address counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_addr_q <= clr_addr_q + kch_pkg::PAT_BITS'(1);
    end
  end

  assign status_o.clear_last = (clr_addr_q == {kch_pkg::PAT_BITS{1'b1}});

  // Saturating increment of the looked-up count.
  always_comb begin
    lim      = (rd_q >= limit_q);
    cnt_inc  = rd_q + kch_pkg::CNT_W'(1);
    do_write = cmd_i.update && !is_read_q && formed_q && !lim;
  end

  // Table write port: zeros during the clearing pass, the new count otherwise.
  always_comb begin
    mem_we    = cmd_i.clear || do_write;
    mem_waddr = cmd_i.clear ? clr_addr_q : pat_q;
    mem_wdata = cmd_i.clear ? '0 : cnt_inc;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
  end

  // Table read port with registered data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.lookup) begin
      rd_q <= table_mem[pat_q];
    end
  end

  // Result; a warm-up base gives an all-zero result.
  always_comb begin
    result_d = '0;
    if (formed_q) begin
      result_d.pattern_code  = pat_q;
      result_d.pattern_count = do_write ? cnt_inc : rd_q;
      result_d.window_full   = 1'b1;
      result_d.at_limit      = lim;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      result_q <= result_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.update;
    end
  end

  assign result_o       = result_q;
  assign result_valid_o = result_valid_q;

endmodule

/* src/kmer_count_histogram.sv */
// Top level of the k-mer counter: controller and datapath joined by command and status.
//
// Each item passes through three steps: the item is taken in the idle state, the count table
// is read in the lookup state, and the count is updated and the result registered in the
// update state. The result strobe result_valid_o is high for one cycle, the first cycle in
// which busy is low again, and the receiver cannot stall it. A new item may be started in the
// cycle that the result is shown. After reset the table is cleared one entry a cycle,
// 4,194,304 entries in all, and busy stays high until that is done; count limit writes are
// taken at any time, but belong in idle periods.
module kmer_count_histogram (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  kch_pkg::kch_in_t          item_i,
  output kch_pkg::kch_out_t         result_o,
  output logic                      result_valid_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [kch_pkg::CNT_W-1:0] cfg_data_i
);

  kch_pkg::kch_cmd_t    cmd;
  kch_pkg::kch_status_t status;

  // Sequencing.
  kch_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  // Window, table and result.
  kch_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .item_i         (item_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .result_o       (result_o),
    .result_valid_o (result_valid_o)
  );

  // Every configuration transfer is taken at once.
  assign cfg_ready_o = 1'b1;

endmodule
